// File: src/pmdm_pkg.sv
// ----------------------------------------------------------------------------
// pmdm_pkg
// Types and constants shared by the dense-matrix minimum spanning tree unit
// and its channel interfaces.
// ----------------------------------------------------------------------------
`default_nettype none

package pmdm_pkg;

	localparam int VERTEX_W     = 4;
	localparam int WEIGHT_W     = 16;
	localparam int COUNT_W      = 5;
	localparam int EDGE_COUNT_W = 4;
	localparam int FIELD_VERTICES = 16;

	localparam logic [COUNT_W-1:0] VERTEX_COUNT_RESET = 5'd16;

	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_RUN  = 1'b1;

	typedef struct packed {
		logic                func;
		logic [VERTEX_W-1:0] row_vertex;
		logic [VERTEX_W-1:0] col_vertex;
		logic [WEIGHT_W-1:0] weight;
		logic [VERTEX_W-1:0] start_vertex;
	} cmd_item_t;

	typedef struct packed {
		logic [VERTEX_W-1:0] edge_from;
		logic [VERTEX_W-1:0] edge_to;
		logic [WEIGHT_W-1:0] edge_weight;
		logic                edge_valid;
		logic                disconnected;
		logic                last;
	} rsp_item_t;

endpackage

`default_nettype wire

// File: src/pmdm_if.sv
// ----------------------------------------------------------------------------
// pmdm channel interfaces
// Valid/ready channels for command transactions and tree edge results.
// ----------------------------------------------------------------------------
`default_nettype none

interface pmdm_cmd_if;
	import pmdm_pkg::*;

	logic      valid;
	logic      ready;
	cmd_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface pmdm_rsp_if;
	import pmdm_pkg::*;

	logic      valid;
	logic      ready;
	rsp_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: src/prim_mst_dense_matrix_unit.sv
// ----------------------------------------------------------------------------
// prim_mst_dense_matrix_unit
// Prim minimum spanning tree over a weighted adjacency matrix held in an
// on-chip memory. One row of the matrix is scanned per round by a shared
// compare unit that keeps per-vertex best edges and the round minimum.
// ----------------------------------------------------------------------------
// load transaction: written straight into the matrix memory
// run transaction: up to (n-1) rounds, each set by one row scan through
//   the single memory read port
// no new transaction is taken during a run; a pending result does not block loads
// arst_n clears the sequencer, vertex_count (to 16) and all flags; the matrix
//   memory has no reset and reads as undefined until written
`default_nettype none

module prim_mst_dense_matrix_unit #(
	parameter int MAX_VERTICES = 16,
	parameter int WEIGHT_BITS  = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [pmdm_pkg::COUNT_W-1:0] cfg_wdata,
	pmdm_cmd_if.sink                    cmd,
	pmdm_rsp_if.source                  rsp
);
	import pmdm_pkg::*;

	localparam int VL = (MAX_VERTICES < FIELD_VERTICES) ? MAX_VERTICES : FIELD_VERTICES;
	localparam int IW = $clog2(VL);
	localparam int AW = 2 * IW;
	localparam int MEM_DEPTH = 1 << AW;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_EMIT  = 2'd3;

	logic [1:0]              state_q;
	logic [COUNT_W-1:0]      cfg_q;
	logic [VL-1:0]           sel_q;
	logic [VL-1:0]           kval_q;
	logic [IW-1:0]           cur_q;
	logic [IW-1:0]           j_q;
	logic [EDGE_COUNT_W-1:0] ecnt_q;
	logic                    found_q;
	logic                    out_valid_q;
	rsp_item_t               out_q;

	logic [WEIGHT_BITS-1:0]  adj_q [MEM_DEPTH];
	logic [WEIGHT_BITS-1:0]  key_q [VL];
	logic [IW-1:0]           par_q [VL];
	logic [WEIGHT_BITS-1:0]  bw_q;
	logic [IW-1:0]           bp_q;
	logic [IW-1:0]           bj_q;

	logic                    sv_s1;
	logic [IW-1:0]           j_s1;
	logic [WEIGHT_BITS-1:0]  rdata_s1;

	logic [COUNT_W-1:0]      n_w;
	logic [COUNT_W-1:0]      nm1_w;
	logic                    cmd_fire;
	logic                    load_we;
	logic                    run_go;
	logic [AW-1:0]           mem_wa;
	logic [AW-1:0]           mem_ra;
	logic [31:0]             wext;
	logic [WEIGHT_BITS-1:0]  old_k;
	logic [IW-1:0]           old_p;
	logic                    old_v;
	logic                    take;
	logic [WEIGHT_BITS-1:0]  new_k;
	logic [IW-1:0]           new_p;
	logic                    better;
	logic                    emit_go;
	logic                    last_w;
	logic [31:0]             bw_ext;

	// active vertex count
	always_comb begin
		if (cfg_q == '0) begin
			n_w = COUNT_W'(1);
		end else if (cfg_q > COUNT_W'(VL)) begin
			n_w = COUNT_W'(VL);
		end else begin
			n_w = cfg_q;
		end
		nm1_w = n_w - COUNT_W'(1);
	end

	assign cmd.ready = (state_q == ST_IDLE);
	assign cmd_fire  = cmd.valid && cmd.ready;
	assign load_we   = cmd_fire && (cmd.data.func == FUNC_LOAD)
		&& (32'(cmd.data.row_vertex) < 32'(MAX_VERTICES))
		&& (32'(cmd.data.col_vertex) < 32'(MAX_VERTICES));
	// a single-vertex graph has no edge to grow, so the command is taken but no run starts
	assign run_go    = cmd_fire && (cmd.data.func == FUNC_RUN)
		&& (COUNT_W'(cmd.data.start_vertex) < n_w) && (n_w > COUNT_W'(1));
	assign mem_wa    = {cmd.data.row_vertex[IW-1:0], cmd.data.col_vertex[IW-1:0]};
	assign mem_ra    = {cur_q, j_q};
	assign wext      = 32'(cmd.data.weight);

	// matrix memory
	always_ff @(posedge clk) begin
		if (load_we) begin
			adj_q[mem_wa] <= wext[WEIGHT_BITS-1:0];
		end
		if (state_q == ST_SCAN) begin
			rdata_s1 <= adj_q[mem_ra];
		end
	end

	// shared compare unit: relax one column, then test it against the round best
	always_comb begin
		old_k  = key_q[j_s1];
		old_p  = par_q[j_s1];
		old_v  = kval_q[j_s1];
		take   = sv_s1 && !sel_q[j_s1] && (rdata_s1 != '0)
			&& (!old_v || (rdata_s1 < old_k) || ((rdata_s1 == old_k) && (cur_q < old_p)));
		new_k  = take ? rdata_s1 : old_k;
		new_p  = take ? cur_q : old_p;
		better = sv_s1 && !sel_q[j_s1] && (old_v || take)
			&& (!found_q || (new_k < bw_q) || ((new_k == bw_q) && (new_p < bp_q)));
	end

	assign emit_go = (state_q == ST_EMIT) && (!out_valid_q || rsp.ready);
	assign last_w  = ((COUNT_W'(ecnt_q) + COUNT_W'(2)) >= n_w);
	assign bw_ext  = 32'(bw_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cfg_q       <= VERTEX_COUNT_RESET;
			sel_q       <= '0;
			kval_q      <= '0;
			cur_q       <= '0;
			j_q         <= '0;
			ecnt_q      <= '0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
			sv_s1       <= 1'b0;
		end else begin
			if (cfg_we) begin
				cfg_q <= cfg_wdata;
			end
			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (rsp.valid && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			sv_s1 <= (state_q == ST_SCAN);
			if (take) begin
				kval_q[j_s1] <= 1'b1;
			end
			if (better) begin
				found_q <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (run_go) begin
						sel_q   <= VL'(1) << cmd.data.start_vertex[IW-1:0];
						kval_q  <= '0;
						cur_q   <= cmd.data.start_vertex[IW-1:0];
						ecnt_q  <= '0;
						j_q     <= '0;
						found_q <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					j_q <= j_q + IW'(1);
					if (COUNT_W'(j_q) == nm1_w) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit_go) begin
						if (!found_q) begin
							state_q <= ST_IDLE;
						end else begin
							sel_q[bj_q] <= 1'b1;
							ecnt_q      <= ecnt_q + EDGE_COUNT_W'(1);
							cur_q       <= bj_q;
							if (last_w) begin
								state_q <= ST_IDLE;
							end else begin
								j_q     <= '0;
								found_q <= 1'b0;
								state_q <= ST_SCAN;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		j_s1 <= j_q;
		if (take) begin
			key_q[j_s1] <= rdata_s1;
			par_q[j_s1] <= cur_q;
		end
		if (better) begin
			bw_q <= new_k;
			bp_q <= new_p;
			bj_q <= j_s1;
		end
		if (emit_go) begin
			if (found_q) begin
				out_q.edge_from    <= VERTEX_W'(bp_q);
				out_q.edge_to      <= VERTEX_W'(bj_q);
				out_q.edge_weight  <= bw_ext[WEIGHT_W-1:0];
				out_q.edge_valid   <= 1'b1;
				out_q.disconnected <= 1'b0;
				out_q.last         <= last_w;
			end else begin
				out_q.edge_from    <= '0;
				out_q.edge_to      <= '0;
				out_q.edge_weight  <= '0;
				out_q.edge_valid   <= 1'b0;
				out_q.disconnected <= 1'b1;
				out_q.last         <= 1'b1;
			end
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	a_edge_xor_disc: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.data.edge_valid != rsp.data.disconnected))
		else $error("result is neither a single edge nor a disconnect marker");

	a_disc_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.data.disconnected) |-> rsp.data.last)
		else $error("disconnect result not marked last");

	a_new_vertex_unselected: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_EMIT) && found_q) |-> !sel_q[bj_q])
		else $error("chosen edge leads to an already selected vertex");

	a_source_selected: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_EMIT) && found_q) |-> sel_q[par_q[bj_q]])
		else $error("chosen edge starts at an unselected vertex");

	a_run_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		run_go |=> ((state_q == ST_SCAN) && (j_q == '0) && !found_q))
		else $error("accepted run did not start a row scan");

endmodule

`default_nettype wire
